/* hw/rtl/audio_peak_meter_with_hold_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the audio peak meter
// Shared property wrappers, clocked on clock and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef AUDIO_PEAK_METER_WITH_HOLD_DEFINES_SVH
`define AUDIO_PEAK_METER_WITH_HOLD_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define APM_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("peak meter check failed");

// Consequent checked in the cycle after the antecedent.
`define APM_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("peak meter check failed");

`endif

/* hw/rtl/apm_pkg.sv */
// ----------------------------------------------------------------------------
// Peak meter package
// Payload types, configuration type, register indexes and fixed widths.
// ----------------------------------------------------------------------------
`default_nettype none

package apm_pkg;

   localparam int SAMPLE_BITS = 16;
   localparam int DECAY_BITS  = 16;
   localparam int COUNT_BITS  = 20;
   localparam int CHAN_BITS   = 2;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 20;

   localparam logic [SAMPLE_BITS-1:0] FULL_SCALE = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam logic [COUNT_BITS-1:0]  COUNT_MAX  = {COUNT_BITS{1'b1}};

   localparam logic [CSR_IDX_BITS-1:0] CSR_DECAY_FACTOR    = 2'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_HOLD_SAMPLES    = 2'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_ACTIVE_CHANNELS = 2'd2;

   localparam logic [DECAY_BITS-1:0] DECAY_RESET  = 16'd65531;
   localparam logic [COUNT_BITS-1:0] HOLD_RESET   = 20'd48000;
   localparam logic [CHAN_BITS-1:0]  CHAN_RESET   = 2'd2;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] sample_a;
      logic signed [SAMPLE_BITS-1:0] sample_b;
      logic                          block_end;
   } apm_req_type;

   typedef struct packed {
      logic [SAMPLE_BITS-1:0] level;
      logic [SAMPLE_BITS-1:0] peak;
   } apm_rsp_type;

   typedef struct packed {
      logic [DECAY_BITS-1:0] decay_factor;
      logic [COUNT_BITS-1:0] hold_samples;
      logic [CHAN_BITS-1:0]  active_channels;
   } apm_cfg_type;

endpackage

`default_nettype wire

/* hw/rtl/audio_peak_meter_with_hold.sv */
// ----------------------------------------------------------------------------
// Audio peak meter with decay and peak hold
// Block-end results pass the lane registers, then the core result register.
// One frame per cycle unless a result is stalled; decay multiply and hold
// compare are combinational. Sync reset clears state, loads register defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module audio_peak_meter_with_hold (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             req_valid,
   output logic                                  req_stall,
   input  wire apm_pkg::apm_req_type             req_payload,
   output logic                                  rsp_valid,
   input  wire logic                             rsp_stall,
   output apm_pkg::apm_rsp_type                  rsp_payload,
   input  wire logic                             csr_write_enable,
   input  wire logic [apm_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  wire logic [apm_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import apm_pkg::*;

   apm_cfg_type            cfg_ff, cfg_in;
   logic                   frame_valid_ff, frame_valid_in;
   logic                   block_end_ff;
   logic                   advance;
   logic [SAMPLE_BITS-1:0] mag_a;
   logic [SAMPLE_BITS-1:0] mag_b;

   // hold the whole pipe while a result waits on a stalled beat
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DECAY_FACTOR:    cfg_in.decay_factor    = csr_wdata[DECAY_BITS-1:0];
            CSR_HOLD_SAMPLES:    cfg_in.hold_samples    = csr_wdata[COUNT_BITS-1:0];
            CSR_ACTIVE_CHANNELS: cfg_in.active_channels = csr_wdata[CHAN_BITS-1:0];
            default:             cfg_in = cfg_ff;
         endcase
      end
      frame_valid_in = advance ? req_valid : frame_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.decay_factor    <= DECAY_RESET;
         cfg_ff.hold_samples    <= HOLD_RESET;
         cfg_ff.active_channels <= CHAN_RESET;
         frame_valid_ff         <= 1'b0;
      end else begin
         cfg_ff         <= cfg_in;
         frame_valid_ff <= frame_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         block_end_ff <= req_payload.block_end;
      end
   end

   apm_lane u_lane_a (
      .clock  (clock),
      .enable (advance),
      .sample (req_payload.sample_a),
      .mag_ff (mag_a)
   );

   apm_lane u_lane_b (
      .clock  (clock),
      .enable (advance),
      .sample (req_payload.sample_b),
      .mag_ff (mag_b)
   );

   apm_core u_core (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .frame_valid  (frame_valid_ff),
      .block_end    (block_end_ff),
      .mag_a        (mag_a),
      .mag_b        (mag_b),
      .cfg          (cfg_ff),
      .rsp_valid_ff (rsp_valid),
      .rsp_ff       (rsp_payload)
   );

endmodule

`default_nettype wire

/* hw/rtl/apm_lane.sv */
// ----------------------------------------------------------------------------
// Peak meter channel lane
// Registered magnitude of one signed sample; most negative gives full scale.
// ----------------------------------------------------------------------------
`default_nettype none

module apm_lane (
   input  wire logic                               clock,
   input  wire logic                               enable,
   input  wire logic signed [apm_pkg::SAMPLE_BITS-1:0] sample,
   output logic [apm_pkg::SAMPLE_BITS-1:0]         mag_ff
);
   import apm_pkg::*;

   logic [SAMPLE_BITS-1:0] mag_in;

   always_comb begin
      if (sample[SAMPLE_BITS-1]) begin
         mag_in = ~sample + 1'b1;
      end else begin
         mag_in = sample;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         mag_ff <= mag_in;
      end
   end

endmodule

`default_nettype wire

/* hw/rtl/apm_core.sv */
// ----------------------------------------------------------------------------
// Peak meter merge and state core
// Merges lane magnitudes, decays the level, runs peak hold, registers result.
// ----------------------------------------------------------------------------
`default_nettype none

module apm_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           advance,
   input  wire logic                           frame_valid,
   input  wire logic                           block_end,
   input  wire logic [apm_pkg::SAMPLE_BITS-1:0] mag_a,
   input  wire logic [apm_pkg::SAMPLE_BITS-1:0] mag_b,
   input  wire apm_pkg::apm_cfg_type           cfg,
   output logic                                rsp_valid_ff,
   output apm_pkg::apm_rsp_type                rsp_ff
);
   import apm_pkg::*;

   logic [SAMPLE_BITS-1:0]            block_max_ff, block_max_in;
   logic [SAMPLE_BITS-1:0]            level_ff, level_in;
   logic [SAMPLE_BITS-1:0]            peak_ff, peak_in;
   logic [COUNT_BITS-1:0]             count_ff, count_in;
   logic                              rsp_valid_in;
   apm_rsp_type                       rsp_in;

   logic [SAMPLE_BITS-1:0]            frame_max;
   logic [SAMPLE_BITS-1:0]            block_max_upd;
   logic [SAMPLE_BITS+DECAY_BITS-1:0] product;
   logic [SAMPLE_BITS-1:0]            level_dec;
   logic [COUNT_BITS-1:0]             count_upd;
   logic [SAMPLE_BITS-1:0]            next_level;
   logic                              refresh;

   always_comb begin
      // second lane only counts with two or more channels
      frame_max = mag_a;
      if (cfg.active_channels[1] && (mag_b > mag_a)) begin
         frame_max = mag_b;
      end
      block_max_upd = (frame_max > block_max_ff) ? frame_max : block_max_ff;

      product   = level_ff * cfg.decay_factor;
      level_dec = product[SAMPLE_BITS+DECAY_BITS-1:DECAY_BITS];

      count_upd = (count_ff == COUNT_MAX) ? count_ff : count_ff + 1'b1;

      next_level = (level_dec > block_max_upd) ? level_dec : block_max_upd;
      if (next_level > FULL_SCALE) begin
         next_level = FULL_SCALE;
      end
      refresh = (peak_ff < next_level) || (count_upd > cfg.hold_samples);

      block_max_in = block_max_ff;
      level_in     = level_ff;
      peak_in      = peak_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (advance) begin
         rsp_valid_in = frame_valid && block_end;
         if (frame_valid) begin
            if (block_end) begin
               block_max_in = '0;
               level_in     = next_level;
               peak_in      = refresh ? next_level : peak_ff;
               count_in     = refresh ? '0 : count_upd;
               rsp_in.level = next_level;
               rsp_in.peak  = refresh ? next_level : peak_ff;
            end else begin
               block_max_in = block_max_upd;
               level_in     = level_dec;
               count_in     = count_upd;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_max_ff <= '0;
         level_ff     <= '0;
         peak_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         block_max_ff <= block_max_in;
         level_ff     <= level_in;
         peak_ff      <= peak_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

endmodule

`default_nettype wire

/* hw/rtl/apm_checker.sv */
// ----------------------------------------------------------------------------
// Peak meter port checker
// Watches the top level ports for range, ordering and stall behaviour.
// ----------------------------------------------------------------------------
`default_nettype none

`include "audio_peak_meter_with_hold_defines.svh"

module apm_checker (
   input wire logic                 clock,
   input wire logic                 reset,
   input wire logic                 req_stall,
   input wire logic                 rsp_valid,
   input wire logic                 rsp_stall,
   input wire apm_pkg::apm_rsp_type rsp_payload
);
   import apm_pkg::*;

   `APM_ASSERT_NOW(level_in_range, rsp_valid, rsp_payload.level <= FULL_SCALE)
   `APM_ASSERT_NOW(peak_not_below_level, rsp_valid, rsp_payload.peak >= rsp_payload.level)
   `APM_ASSERT_NOW(stall_only_behind_result, req_stall, rsp_valid && rsp_stall)
   `APM_ASSERT_NEXT(result_held, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

endmodule

bind audio_peak_meter_with_hold apm_checker u_apm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
